/* rtl/tccw_pkg.sv */
// Shared types and constants of the text console character writer.
package tccw_pkg;
	localparam int MaxCols  = 128;
	localparam int MaxRows  = 32;
	localparam int TabStop  = 4;
	localparam int Depth    = MaxCols * MaxRows;
	localparam int AddrW    = $clog2(Depth);
	localparam int QDepth   = 4;
	localparam int QPtrW    = $clog2(QDepth);

	localparam logic [1:0] FUNC_PUT   = 2'd0;
	localparam logic [1:0] FUNC_CLEAR = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	localparam logic [1:0] REG_COLUMNS = 2'd0;
	localparam logic [1:0] REG_ROWS    = 2'd1;
	localparam logic [1:0] REG_FILL    = 2'd2;

	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;

	typedef enum logic [1:0] {
		OP_PUT,
		OP_TAB,
		OP_CLEAR,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       nop;
		logic [7:0] ch;
		logic [6:0] rc;
		logic [4:0] rr;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PUT,
		ST_SCROLL_RD,
		ST_SCROLL_WR,
		ST_FILL,
		ST_CLEAR,
		ST_READ,
		ST_READ_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [6:0]  cursor_col;
		logic [4:0]  cursor_row;
		logic [11:0] cursor_linear;
		logic        scrolled;
		logic [7:0]  cell_char;
		logic [7:0]  cell_color;
	} res_t;
endpackage

/* rtl/tccw_if.sv */
// Valid/ready channel interfaces of the console.
interface tccw_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] char_code;
	logic [6:0] read_col;
	logic [4:0] read_row;
	modport source(output valid, func, char_code, read_col, read_row, input ready);
	modport sink(input valid, func, char_code, read_col, read_row, output ready);
endinterface

interface tccw_out_if;
	logic        valid;
	logic        ready;
	logic [6:0]  cursor_col;
	logic [4:0]  cursor_row;
	logic [11:0] cursor_linear;
	logic        scrolled;
	logic [7:0]  cell_char;
	logic [7:0]  cell_color;
	modport source(output valid, cursor_col, cursor_row, cursor_linear, scrolled, cell_char,
		cell_color, input ready);
	modport sink(input valid, cursor_col, cursor_row, cursor_linear, scrolled, cell_char,
		cell_color, output ready);
endinterface

/* rtl/tccw_front.sv */
// Front end: classifies input words into commands and queues them.
module tccw_front (
	input  logic                clk,
	input  logic                arst_n,
	tccw_in_if.sink             in_ch,
	output logic                cmd_valid,
	input  logic                cmd_ready,
	output tccw_pkg::cmd_t      cmd
);
	tccw_pkg::cmd_t                 q_mem_q [tccw_pkg::QDepth];
	logic [tccw_pkg::QPtrW-1:0]     wr_q, rd_q;
	logic [tccw_pkg::QPtrW:0]       cnt_q;
	tccw_pkg::cmd_t                 c;
	logic                           push, pop;

	always_comb begin
		c = '0;
		c.ch = in_ch.char_code;
		c.rc = in_ch.read_col;
		c.rr = in_ch.read_row;
		unique case (in_ch.func)
			tccw_pkg::FUNC_PUT:   c.op = (in_ch.char_code == tccw_pkg::CH_TAB) ?
				tccw_pkg::OP_TAB : tccw_pkg::OP_PUT;
			tccw_pkg::FUNC_CLEAR: c.op = tccw_pkg::OP_CLEAR;
			tccw_pkg::FUNC_READ:  c.op = tccw_pkg::OP_READ;
			default: begin
				c.op = tccw_pkg::OP_READ;
				c.nop = 1'b1;
			end
		endcase
	end

	assign in_ch.ready = (cnt_q != (tccw_pkg::QPtrW+1)'(tccw_pkg::QDepth));
	assign push = in_ch.valid && in_ch.ready;
	assign cmd_valid = (cnt_q != '0);
	assign pop = cmd_valid && cmd_ready;
	assign cmd = q_mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) q_mem_q[wr_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (tccw_pkg::QPtrW+1)'(push) - (tccw_pkg::QPtrW+1)'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (tccw_pkg::QPtrW+1)'(tccw_pkg::QDepth)) else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> !cmd_valid) else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");
endmodule

/* rtl/tccw_back.sv */
// Back end: executes commands against the character and color stores.
module tccw_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  tccw_pkg::cmd_t      cmd,
	input  logic [7:0]          cfg_cols,
	input  logic [5:0]          cfg_rows,
	input  logic [7:0]          cfg_fill,
	tccw_out_if.source          out_ch
);
	logic [7:0] chr_mem [tccw_pkg::Depth];
	logic [7:0] col_mem [tccw_pkg::Depth];

	tccw_pkg::state_t st_q, st_d;
	tccw_pkg::cmd_t   cmd_q;
	logic [6:0]  col_q;
	logic [4:0]  row_q;
	logic        scr_q;
	logic [tccw_pkg::AddrW:0] ptr_q;  // sweep pointer
	logic [tccw_pkg::AddrW:0] clr_q;  // post-reset clearing pass, done at Depth
	logic [7:0]  rd_chr_q, rd_col_q, mv_chr_q, mv_col_q;
	logic        inb_q;
	logic        ov_q;
	tccw_pkg::res_t res_q;
	logic        ovld_q;

	logic [7:0]  w;
	logic [6:0]  h;
	logic [12:0] total, lin;
	logic [7:0]  ncol;
	logic [5:0]  nrow;
	logic        wr_en;
	logic [tccw_pkg::AddrW-1:0] wr_a, rd_a;
	logic [7:0]  wr_c, wr_k;
	logic        wr_k_en;
	logic        clearing;
	logic [7:0]  c_ch;

	assign w = (cfg_cols == 8'd0) ? 8'd1 :
		(cfg_cols > 8'(tccw_pkg::MaxCols)) ? 8'(tccw_pkg::MaxCols) : cfg_cols;
	assign h = (cfg_rows == 6'd0) ? 7'd1 :
		(cfg_rows > 6'(tccw_pkg::MaxRows)) ? 7'(tccw_pkg::MaxRows) : {1'b0, cfg_rows};
	assign total = 13'(w) * 13'(h);
	assign lin = 13'({8'd0, row_q} * w) + 13'(col_q);
	assign clearing = !clr_q[tccw_pkg::AddrW];
	assign cmd_ready = (st_q == tccw_pkg::ST_IDLE) && !clearing && !ovld_q;

	// Cursor after one character step, before scrolling.
	always_comb begin
		c_ch = (cmd_q.op == tccw_pkg::OP_TAB) ? tccw_pkg::CH_SPACE : cmd_q.ch;
		ncol = {1'b0, col_q};
		nrow = {1'b0, row_q};
		if (c_ch == tccw_pkg::CH_NL) begin
			ncol = 8'd0;
			nrow = nrow + 6'd1;
		end else if (c_ch == tccw_pkg::CH_CR) begin
			ncol = 8'd0;
		end else begin
			ncol = ncol + 8'd1;
		end
		if (ncol >= w) begin
			ncol = 8'd0;
			nrow = nrow + 6'd1;
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			tccw_pkg::ST_IDLE: if (cmd_valid && cmd_ready) begin
				if (cmd.nop) st_d = tccw_pkg::ST_DONE;
				else unique case (cmd.op)
					tccw_pkg::OP_PUT, tccw_pkg::OP_TAB: st_d = tccw_pkg::ST_PUT;
					tccw_pkg::OP_CLEAR: st_d = tccw_pkg::ST_CLEAR;
					default: st_d = tccw_pkg::ST_READ;
				endcase
			end
			tccw_pkg::ST_PUT: begin
				if ({1'b0, nrow} >= h) st_d = tccw_pkg::ST_SCROLL_RD;
				else if (cmd_q.op == tccw_pkg::OP_TAB &&
					(ncol % 8'(tccw_pkg::TabStop)) != 8'd0)
					st_d = tccw_pkg::ST_PUT;
				else st_d = tccw_pkg::ST_DONE;
			end
			tccw_pkg::ST_SCROLL_RD: st_d = (ptr_q + 14'(w) >= 14'(total)) ?
				tccw_pkg::ST_FILL : tccw_pkg::ST_SCROLL_WR;
			tccw_pkg::ST_SCROLL_WR: st_d = tccw_pkg::ST_SCROLL_RD;
			tccw_pkg::ST_FILL: if (ptr_q + 14'd1 >= 14'(total)) begin
				st_d = (cmd_q.op == tccw_pkg::OP_TAB &&
					(col_q % 7'(tccw_pkg::TabStop)) != 7'd0) ?
					tccw_pkg::ST_PUT : tccw_pkg::ST_DONE;
			end
			tccw_pkg::ST_CLEAR: if (ptr_q + 14'd1 >= 14'(total)) st_d = tccw_pkg::ST_DONE;
			tccw_pkg::ST_READ: st_d = tccw_pkg::ST_READ_WAIT;
			tccw_pkg::ST_READ_WAIT: st_d = tccw_pkg::ST_DONE;
			tccw_pkg::ST_DONE: if (!ovld_q) st_d = tccw_pkg::ST_IDLE;
			default: st_d = tccw_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		wr_en = 1'b0;
		wr_k_en = 1'b0;
		wr_a = lin[tccw_pkg::AddrW-1:0];
		wr_c = c_ch;
		wr_k = cfg_fill;
		rd_a = (ptr_q + 14'(w)) >= 14'(tccw_pkg::Depth) ? '0 :
			tccw_pkg::AddrW'(ptr_q + 14'(w));
		if (clearing) begin
			wr_en = 1'b1;
			wr_k_en = 1'b1;
			wr_a = clr_q[tccw_pkg::AddrW-1:0];
			wr_c = 8'd0;
			wr_k = 8'd7;
		end else begin
			unique case (st_q)
				tccw_pkg::ST_PUT: wr_en = (c_ch != tccw_pkg::CH_NL) &&
					(c_ch != tccw_pkg::CH_CR) && ({1'b0, col_q} < w) && ({2'b0, row_q} < h);
				tccw_pkg::ST_SCROLL_WR: begin
					wr_en = 1'b1;
					wr_k_en = 1'b1;
					wr_a = tccw_pkg::AddrW'(ptr_q);
					wr_c = mv_chr_q;
					wr_k = mv_col_q;
				end
				tccw_pkg::ST_FILL, tccw_pkg::ST_CLEAR: begin
					wr_en = 1'b1;
					wr_k_en = 1'b1;
					wr_a = tccw_pkg::AddrW'(ptr_q);
					wr_c = 8'd0;
				end
				// The cell address is held in both read states so that the
				// data register still holds the cell when the result is built.
				tccw_pkg::ST_READ, tccw_pkg::ST_READ_WAIT:
					rd_a = tccw_pkg::AddrW'(13'({8'd0, cmd_q.rr} * w) + 13'(cmd_q.rc));
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) chr_mem[wr_a] <= wr_c;
		if (wr_k_en) col_mem[wr_a] <= wr_k;
		rd_chr_q <= chr_mem[rd_a];
		rd_col_q <= col_mem[rd_a];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= tccw_pkg::ST_IDLE;
			clr_q <= '0;
			col_q <= '0;
			row_q <= '0;
			ptr_q <= '0;
			scr_q <= 1'b0;
			ovld_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (clearing) clr_q <= clr_q + 1'b1;
			st_q <= st_d;
			if (ovld_q && out_ch.ready) ovld_q <= 1'b0;
			unique case (st_q)
				tccw_pkg::ST_IDLE: if (cmd_valid && cmd_ready) begin
					cmd_q <= cmd;
					scr_q <= 1'b0;
					ptr_q <= '0;
				end
				tccw_pkg::ST_PUT: begin
					col_q <= ncol[6:0];
					if ({1'b0, nrow} >= h) begin
						row_q <= 5'(h - 7'd1);
						scr_q <= 1'b1;
						ptr_q <= '0;
					end else row_q <= nrow[4:0];
				end
				tccw_pkg::ST_SCROLL_RD: if (ptr_q + 14'(w) >= 14'(total)) ptr_q <= ptr_q;
				tccw_pkg::ST_SCROLL_WR: ptr_q <= ptr_q + 1'b1;
				tccw_pkg::ST_FILL, tccw_pkg::ST_CLEAR: begin
					ptr_q <= ptr_q + 1'b1;
					if (st_q == tccw_pkg::ST_CLEAR) begin
						col_q <= '0;
						row_q <= '0;
					end
				end
				tccw_pkg::ST_READ: ov_q <= ({1'b0, cmd_q.rc} < w) && ({2'b0, cmd_q.rr} < h);
				tccw_pkg::ST_DONE: if (!ovld_q) begin
					ovld_q <= 1'b1;
					res_q.cursor_col <= col_q;
					res_q.cursor_row <= row_q;
					res_q.cursor_linear <= lin[11:0];
					res_q.scrolled <= scr_q;
					res_q.cell_char <= (cmd_q.op == tccw_pkg::OP_READ && !cmd_q.nop && inb_q) ?
						rd_chr_q : 8'd0;
					res_q.cell_color <= (cmd_q.op == tccw_pkg::OP_READ && !cmd_q.nop && inb_q) ?
						rd_col_q : 8'd0;
				end
				default: ;
			endcase
		end
	end

	// The read data of a scroll step is captured for the following write.
	always_ff @(posedge clk) begin
		inb_q <= ov_q;
		if (st_q == tccw_pkg::ST_SCROLL_RD) begin
			mv_chr_q <= chr_mem[rd_a];
			mv_col_q <= col_mem[rd_a];
		end
	end

	assign out_ch.valid = ovld_q;
	assign out_ch.cursor_col = res_q.cursor_col;
	assign out_ch.cursor_row = res_q.cursor_row;
	assign out_ch.cursor_linear = res_q.cursor_linear;
	assign out_ch.scrolled = res_q.scrolled;
	assign out_ch.cell_char = res_q.cell_char;
	assign out_ch.cell_color = res_q.cell_color;

	assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> st_q == tccw_pkg::ST_IDLE) else $error("work during clearing pass");
	assert property (@(posedge clk) disable iff (!arst_n)
		st_q == tccw_pkg::ST_SCROLL_WR |=> st_q == tccw_pkg::ST_SCROLL_RD)
		else $error("scroll step order");
	assert property (@(posedge clk) disable iff (!arst_n)
		ovld_q && !out_ch.ready |=> ovld_q && $stable(res_q)) else $error("result lost");
endmodule

/* rtl/text_console_char_writer_core.sv */
// Top level of the text console character writer.
// Channels: in_ch carries command words (func, char_code, read_col,
// read_row); out_ch carries one result word per command. Both use
// valid/ready and move a word at a clock edge where both are high.
// Configuration registers columns, rows and fill_color are written through
// cfg_we, cfg_index and cfg_data; the user must write them only while the
// block is idle, which the block itself does not enforce.
// A four-entry command queue decouples the accepting front end from the
// executing back end. From the queue head a plain character passes through
// the put and done states and a read through the read, read-wait and done
// states; a tab repeats the put state for each extra space. A scroll walks
// the screen through the store pair with a read state and a write state per
// cell, then fills the new line; a clear writes every cell in turn. The
// back end takes a new command only once the result register is empty.
// After reset a clearing pass writes every store entry before the first
// command runs; words are still queued meanwhile.
// When the receiver stalls, the result register holds its word, the back
// end waits, and the queue fills before in_ch drops ready.
module text_console_char_writer_core (
	input  logic        clk,
	input  logic        arst_n,
	tccw_in_if.sink     in_ch,
	tccw_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	logic [7:0] cols_q;
	logic [5:0] rows_q;
	logic [7:0] fill_q;
	logic       cmd_valid, cmd_ready;
	tccw_pkg::cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= 8'd80;
			rows_q <= 6'd25;
			fill_q <= 8'd7;
		end else if (cfg_we) begin
			case (cfg_index)
				tccw_pkg::REG_COLUMNS: cols_q <= cfg_data;
				tccw_pkg::REG_ROWS:    rows_q <= cfg_data[5:0];
				tccw_pkg::REG_FILL:    fill_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tccw_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
	);

	tccw_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
		.cmd(cmd), .cfg_cols(cols_q), .cfg_rows(rows_q), .cfg_fill(fill_q),
		.out_ch(out_ch)
	);
endmodule

/* bench/tccw_checker.sv */
// Checker of the console: predicts each result word from the command words and compares.
module tccw_checker (
	input  logic       clk,
	input  logic       arst_n,
	tccw_in_if         in_ch,
	tccw_out_if        out_ch,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	output int         fails,
	output int         pending,
	output int         scrolls
);
	logic [7:0] screen_chars [tccw_pkg::Depth];
	logic [7:0] screen_attrs [tccw_pkg::Depth];
	int unsigned cols_reg, rows_reg, fill_reg;
	int unsigned cur_x, cur_y;
	bit scroll_flag;
	tccw_pkg::res_t expected_q [$];

	function automatic int unsigned width_now();
		if (cols_reg == 0) return 1;
		if (cols_reg > tccw_pkg::MaxCols) return tccw_pkg::MaxCols;
		return cols_reg;
	endfunction

	function automatic int unsigned height_now();
		if (rows_reg == 0) return 1;
		if (rows_reg > tccw_pkg::MaxRows) return tccw_pkg::MaxRows;
		return rows_reg;
	endfunction

	// Store index of a cell; the store wraps at its depth.
	function automatic logic [11:0] cell_at(int unsigned x, int unsigned y, int unsigned w);
		return 12'(y * w + x);
	endfunction

	function void scroll_screen();
		int unsigned w, total;
		w = width_now();
		total = w * height_now();
		for (int unsigned i = 0; i + w < total; i++) begin
			screen_chars[i] = screen_chars[i + w];
			screen_attrs[i] = screen_attrs[i + w];
		end
		for (int unsigned i = total - w; i < total; i++) begin
			screen_chars[i] = 8'd0;
			screen_attrs[i] = fill_reg[7:0];
		end
		scroll_flag = 1'b1;
	endfunction

	function void print_byte(logic [7:0] ch);
		int unsigned w, h;
		w = width_now();
		h = height_now();
		if (ch == tccw_pkg::CH_NL) begin
			cur_x = 0;
			cur_y++;
		end else if (ch == tccw_pkg::CH_CR) begin
			cur_x = 0;
		end else begin
			// A cursor left off screen by a new geometry does not store.
			if (cur_x < w && cur_y < h)
				screen_chars[cell_at(cur_x, cur_y, w)] = ch;
			cur_x++;
		end
		if (cur_x >= w) begin
			cur_y++;
			cur_x = 0;
		end
		if (cur_y >= h) begin
			scroll_screen();
			cur_y = h - 1;
		end
	endfunction

	function tccw_pkg::res_t run_command(logic [1:0] fn, logic [7:0] ch, logic [6:0] rc,
		logic [4:0] rr);
		tccw_pkg::res_t r;
		int unsigned w, h;
		w = width_now();
		h = height_now();
		r = '0;
		scroll_flag = 1'b0;
		if (fn == tccw_pkg::FUNC_PUT) begin
			if (ch == tccw_pkg::CH_TAB) begin
				do print_byte(tccw_pkg::CH_SPACE); while (cur_x % tccw_pkg::TabStop != 0);
			end else begin
				print_byte(ch);
			end
		end else if (fn == tccw_pkg::FUNC_CLEAR) begin
			for (int unsigned i = 0; i < w * h; i++) begin
				screen_chars[i] = 8'd0;
				screen_attrs[i] = fill_reg[7:0];
			end
			cur_x = 0;
			cur_y = 0;
		end else if (fn == tccw_pkg::FUNC_READ) begin
			if (32'(rc) < w && 32'(rr) < h) begin
				r.cell_char = screen_chars[cell_at(32'(rc), 32'(rr), w)];
				r.cell_color = screen_attrs[cell_at(32'(rc), 32'(rr), w)];
			end
		end
		r.cursor_col = cur_x[6:0];
		r.cursor_row = cur_y[4:0];
		r.cursor_linear = 12'(cur_y * width_now() + cur_x);
		r.scrolled = scroll_flag;
		return r;
	endfunction

	function void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tccw_pkg::res_t want;
		if (!arst_n) begin
			for (int i = 0; i < tccw_pkg::Depth; i++) begin
				screen_chars[i] = 8'd0;
				screen_attrs[i] = 8'd7;
			end
			cols_reg = 80;
			rows_reg = 25;
			fill_reg = 7;
			cur_x = 0;
			cur_y = 0;
			expected_q.delete();
			fails = 0;
			scrolls = 0;
			pending = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_q.size() == 0) begin
					$error("result word with no command waiting");
					fails++;
				end else begin
					want = expected_q.pop_front();
					compare_field("cursor_col", 32'(want.cursor_col), 32'(out_ch.cursor_col));
					compare_field("cursor_row", 32'(want.cursor_row), 32'(out_ch.cursor_row));
					compare_field("cursor_linear", 32'(want.cursor_linear),
						32'(out_ch.cursor_linear));
					compare_field("scrolled", 32'(want.scrolled), 32'(out_ch.scrolled));
					compare_field("cell_char", 32'(want.cell_char), 32'(out_ch.cell_char));
					compare_field("cell_color", 32'(want.cell_color), 32'(out_ch.cell_color));
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				want = run_command(in_ch.func, in_ch.char_code, in_ch.read_col, in_ch.read_row);
				if (want.scrolled)
					scrolls++;
				expected_q.push_back(want);
			end
			if (cfg_we) begin
				case (cfg_index)
					tccw_pkg::REG_COLUMNS: cols_reg = 32'(cfg_data);
					tccw_pkg::REG_ROWS: rows_reg = 32'(cfg_data[5:0]);
					tccw_pkg::REG_FILL: fill_reg = 32'(cfg_data);
					default: ;
				endcase
			end
			pending = expected_q.size();
		end
	end
endmodule

/* bench/tb.sv */
// Top of the console testbench: clock, reset, command stimulus and verdict.
module tb;
	localparam logic [1:0] FUNC_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = tccw_pkg::REG_COLUMNS;
	logic [7:0] cfg_data = 8'd0;
	int fails, pending, scrolls;
	int words_sent = 0;
	int geometries = 0;
	bit long_stall = 1'b0;

	tccw_in_if in_ch ();
	tccw_out_if out_ch ();

	text_console_char_writer_core uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	tccw_checker checker_i (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fails(fails), .pending(pending), .scrolls(scrolls)
	);

	always #1 clk = ~clk;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.func = tccw_pkg::FUNC_PUT;
		in_ch.char_code = 8'd0;
		in_ch.read_col = 7'd0;
		in_ch.read_row = 5'd0;
		out_ch.ready = 1'b0;
	end

	// The receiver stalls on its own pattern, and once for a long stretch.
	initial begin
		int mode;
		mode = 0;
		forever begin
			@(posedge clk);
			if (long_stall) begin
				out_ch.ready <= 1'b0;
				repeat (400) @(posedge clk);
				long_stall = 1'b0;
			end else begin
				if ($urandom_range(0, 63) == 0)
					mode = $urandom_range(0, 2);
				case (mode)
					0: out_ch.ready <= 1'b1;
					1: out_ch.ready <= ($urandom_range(0, 3) != 0);
					default: out_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	task automatic send_word(logic [1:0] fn, logic [7:0] ch, logic [6:0] rc, logic [4:0] rr);
		in_ch.valid <= 1'b1;
		in_ch.func <= fn;
		in_ch.char_code <= ch;
		in_ch.read_col <= rc;
		in_ch.read_row <= rr;
		do @(posedge clk); while (!in_ch.ready);
		words_sent++;
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_geometry(logic [7:0] c, logic [7:0] r, logic [7:0] f);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= tccw_pkg::REG_COLUMNS;
		cfg_data <= c;
		@(posedge clk);
		cfg_index <= tccw_pkg::REG_ROWS;
		cfg_data <= r;
		@(posedge clk);
		cfg_index <= tccw_pkg::REG_FILL;
		cfg_data <= f;
		@(posedge clk);
		cfg_we <= 1'b0;
		geometries++;
	endtask

	task automatic random_word();
		int pick;
		logic [7:0] ch;
		pick = $urandom_range(0, 99);
		ch = 8'($urandom_range(32, 126));
		if (pick < 12) ch = tccw_pkg::CH_NL;
		else if (pick < 18) ch = tccw_pkg::CH_CR;
		else if (pick < 28) ch = tccw_pkg::CH_TAB;
		else if (pick < 36) ch = 8'($urandom_range(0, 255));
		if (pick < 75)
			send_word(tccw_pkg::FUNC_PUT, ch, 7'($urandom), 5'($urandom));
		else if (pick < 77)
			send_word(tccw_pkg::FUNC_CLEAR, 8'($urandom), 7'($urandom), 5'($urandom));
		else if (pick < 97)
			send_word(tccw_pkg::FUNC_READ, 8'($urandom), 7'($urandom_range(0, 127)),
				5'($urandom_range(0, 31)));
		else
			send_word(FUNC_SPARE, 8'($urandom), 7'($urandom), 5'($urandom));
	endtask

	task automatic random_run(int count);
		int left, burst;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 12);
			while (burst > 0 && left > 0) begin
				random_word();
				burst--;
				left--;
			end
			if ($urandom_range(0, 2) != 0) begin
				in_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words on the reset geometry.
		send_word(tccw_pkg::FUNC_PUT, "A", 7'd0, 5'd0);
		send_word(tccw_pkg::FUNC_PUT, 8'd0, 7'd0, 5'd0);
		send_word(tccw_pkg::FUNC_PUT, 8'd255, 7'd127, 5'd31);
		send_word(tccw_pkg::FUNC_PUT, tccw_pkg::CH_TAB, 7'd0, 5'd0);
		send_word(tccw_pkg::FUNC_PUT, tccw_pkg::CH_TAB, 7'd0, 5'd0);
		send_word(tccw_pkg::FUNC_PUT, tccw_pkg::CH_NL, 7'd0, 5'd0);
		send_word(tccw_pkg::FUNC_PUT, tccw_pkg::CH_CR, 7'd0, 5'd0);
		send_word(tccw_pkg::FUNC_READ, 8'd0, 7'd0, 5'd0);
		send_word(tccw_pkg::FUNC_READ, 8'd255, 7'd2, 5'd0);
		send_word(tccw_pkg::FUNC_READ, 8'd0, 7'd127, 5'd31);
		send_word(tccw_pkg::FUNC_READ, 8'd0, 7'd79, 5'd24);
		send_word(FUNC_SPARE, 8'd255, 7'd127, 5'd31);
		send_word(tccw_pkg::FUNC_CLEAR, 8'd0, 7'd0, 5'd0);
		send_word(tccw_pkg::FUNC_READ, 8'd0, 7'd0, 5'd0);
		repeat (24) send_word(tccw_pkg::FUNC_PUT, tccw_pkg::CH_NL, 7'd0, 5'd0);
		send_word(tccw_pkg::FUNC_READ, 8'd0, 7'd0, 5'd24);

		// Shrink the screen under a cursor at column 70, then put.
		repeat (70) send_word(tccw_pkg::FUNC_PUT, "x", 7'd0, 5'd0);
		set_geometry(8'd20, 8'd4, 8'd200);
		send_word(tccw_pkg::FUNC_PUT, "y", 7'd0, 5'd0);
		send_word(tccw_pkg::FUNC_READ, 8'd0, 7'd0, 5'd3);

		set_geometry(8'd1, 8'd1, 8'd0);
		random_run(60);
		set_geometry(8'd0, 8'd0, 8'd255);
		random_run(40);
		set_geometry(8'd4, 8'd3, 8'h5a);
		random_run(150);

		// The receiver holds off while the sender keeps offering words.
		long_stall = 1'b1;
		random_run(40);
		set_geometry(8'd7, 8'd5, 8'ha5);
		random_run(180);
		set_geometry(8'd255, 8'd63, 8'h81);
		random_run(20);
		set_geometry(8'd128, 8'd32, 8'h18);
		random_run(15);
		set_geometry(8'd10, 8'd2, 8'h3c);
		random_run(170);
		// One pause of the sender until every result is back.
		drain();
		random_run(30);
		set_geometry(8'd3, 8'd8, 8'hf0);
		random_run(150);
		set_geometry(8'd16, 8'd4, 8'h0f);
		random_run(110);
		set_geometry(8'd80, 8'd25, 8'd7);
		random_run(25);

		drain();
		repeat (50) @(posedge clk);
		$display("Covered %0d command words over %0d screen geometries.", words_sent,
			geometries + 1);
		$display("%0d words scrolled the screen.", scrolls);
		if (fails == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#20000000;
		$display("TB_ERROR");
		$finish;
	end
endmodule
